// ===== rtl/ttl_pkg.sv =====
// shared types, constants and angle table for the thrust tilt limiter
`timescale 1ns / 1ps
`default_nettype none
package ttl_pkg;

    localparam int IN_W       = 32;
    localparam int DIR_W      = 16;
    localparam int ANG_W      = 15;
    localparam int CFG_IDX_W  = 1;
    localparam int CORDIC_N   = 18;
    localparam int SQRT_N     = 32;
    localparam int DIV_N      = 16;

    localparam logic [ANG_W-1:0] PI_Q13     = 15'd25736;
    localparam logic [ANG_W-1:0] ENABLE_MIN = 15'd9;
    localparam logic signed [19:0] HALF_PI_Q16 = 20'sd102944;
    localparam logic signed [33:0] GAIN_Q30    = 34'sd652032874;
    localparam logic signed [DIR_W-1:0] UNIT_Q14 = 16'sd16384;

    localparam logic [CFG_IDX_W-1:0] CFG_FAIL  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_CLAMP = 1'b1;

    // magnitudes after normalising, with the signs of the raw components
    typedef struct packed {
        logic [31:0] ax;
        logic [31:0] ay;
        logic [31:0] az;
        logic        nx;
        logic        ny;
        logic        nz;
        logic        zero;
    } t_vec;

    function automatic logic signed [19:0] atan_q16(input int i);
        logic signed [19:0] v;
        case (i)
            0:       v = 20'sd51472;
            1:       v = 20'sd30386;
            2:       v = 20'sd16055;
            3:       v = 20'sd8150;
            4:       v = 20'sd4091;
            5:       v = 20'sd2047;
            6:       v = 20'sd1024;
            7:       v = 20'sd512;
            8:       v = 20'sd256;
            9:       v = 20'sd128;
            10:      v = 20'sd64;
            11:      v = 20'sd32;
            12:      v = 20'sd16;
            13:      v = 20'sd8;
            14:      v = 20'sd4;
            15:      v = 20'sd2;
            16:      v = 20'sd1;
            default: v = 20'sd0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/ttl_front.sv =====
// front end: takes force words, forms magnitudes and normalises them
`timescale 1ns / 1ps
`default_nettype none
module ttl_front
    import ttl_pkg::*;
(
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_s_tvalid,
    output logic                 o_s_tready,
    input  wire logic [95:0]     i_s_tdata,
    input  wire logic            i_q_ready,
    output logic                 o_q_push,
    output t_vec                 o_q_data
);

    logic        r_a_vld, r_b_vld;
    logic [31:0] r_ax, r_ay, r_az, r_m;
    logic        r_nx, r_ny, r_nz;
    t_vec        r_b;
    logic        en;
    logic [31:0] n_ax, n_ay, n_az, n_m;
    logic [4:0]  sh;
    t_vec        n_b;

    function automatic logic [31:0] mag(input logic [31:0] u);
        return u[31] ? (32'd0 - u) : u;
    endfunction

    assign en         = !r_b_vld || i_q_ready;
    assign o_s_tready = en;
    assign o_q_push   = r_b_vld && i_q_ready;
    assign o_q_data   = r_b;

    always_comb begin
        n_ax = mag(i_s_tdata[31:0]);
        n_ay = mag(i_s_tdata[63:32]);
        n_az = mag(i_s_tdata[95:64]);
        n_m  = n_ax;
        if (n_ay > n_m) begin
            n_m = n_ay;
        end
        if (n_az > n_m) begin
            n_m = n_az;
        end
    end

    // shift so that the largest magnitude reaches bit 30; one already at bit 31 is not shifted
    always_comb begin
        sh = 5'd0;
        for (int i = 0; i < 30; i++) begin
            if (r_m[i]) begin
                sh = 5'(30 - i);
            end
        end
        if (r_m[31] || r_m[30]) begin
            sh = 5'd0;
        end
        n_b.ax   = r_ax << sh;
        n_b.ay   = r_ay << sh;
        n_b.az   = r_az << sh;
        n_b.nx   = r_nx;
        n_b.ny   = r_ny;
        n_b.nz   = r_nz;
        n_b.zero = (r_m == 32'd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
        end else if (en) begin
            r_a_vld <= i_s_tvalid;
            r_b_vld <= r_a_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ax <= n_ax;
            r_ay <= n_ay;
            r_az <= n_az;
            r_m  <= n_m;
            r_nx <= i_s_tdata[31];
            r_ny <= i_s_tdata[63];
            r_nz <= i_s_tdata[95];
            r_b  <= n_b;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/ttl_fifo.sv =====
// short queue between the front end and the arithmetic pipeline
`timescale 1ns / 1ps
`default_nettype none
module ttl_fifo
    import ttl_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  t_vec      i_data,
    output logic      o_ready,
    input  wire logic i_pop,
    output logic      o_valid,
    output t_vec      o_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_vec          r_mem [DEPTH];
    logic [PW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_cnt;
    logic          push_ok, pop_ok;

    assign o_ready = (r_cnt != CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];
    assign push_ok = i_push && o_ready;
    assign pop_ok  = i_pop && o_valid;

    function automatic logic [PW-1:0] inc(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push_ok) begin
                r_wr <= inc(r_wr);
            end
            if (pop_ok) begin
                r_rd <= inc(r_rd);
            end
            if (push_ok && !pop_ok) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (pop_ok && !push_ok) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/ttl_back.sv =====
// back end: roots, tilt cordic, clamp cordic and dividers, one stage per step
`timescale 1ns / 1ps
`default_nettype none
module ttl_back
    import ttl_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_q_valid,
    input  t_vec                  i_q_data,
    output logic                  o_q_pop,
    input  wire logic [ANG_W-1:0] i_fail_lim,
    input  wire logic [ANG_W-1:0] i_clamp,
    output logic                  o_m_tvalid,
    input  wire logic             i_m_tready,
    output logic                  o_m_tuser,
    output logic [47:0]           o_m_tdata
);

    localparam int K_SQRT = 2;
    localparam int K_VEC  = K_SQRT + SQRT_N;
    localparam int K_DEC  = K_VEC + CORDIC_N;
    localparam int K_NUM  = K_DEC + 1;
    localparam int K_DIV  = K_NUM + 1;
    localparam int NS     = K_DIV + DIV_N;

    typedef struct packed {
        t_vec               iv;
        logic [63:0]        qx, qy, qz;
        logic [63:0]        v2, r2, v3, r3;
        logic signed [33:0] cx, cy;
        logic signed [19:0] cz;
        logic signed [35:0] vx, vy;
        logic signed [19:0] va;
        logic [ANG_W-1:0]   th;
        logic               rej, clp;
        logic [62:0]        px, py;
        logic [48:0]        den;
        logic [64:0]        mx, my, mz;
        logic [15:0]        qxq, qyq, qzq;
    } t_wk;

    t_wk  r_p [NS];
    t_wk  n_p [NS];
    logic r_v [NS];
    logic en;

    logic                   r_ov, r_acc;
    logic [DIR_W-1:0]       r_dx, r_dy, r_dz;
    logic [DIR_W-1:0]       n_dx, n_dy, n_dz;

    assign en      = !r_ov || i_m_tready;
    assign o_q_pop = en && i_q_valid;

    for (genvar k = 0; k < NS; k++) begin : g_stage
        if (k == 0) begin : g_sq
            always_comb begin
                n_p[k]    = '0;
                n_p[k].iv = i_q_data;
                n_p[k].qx = {32'd0, i_q_data.ax} * {32'd0, i_q_data.ax};
                n_p[k].qy = {32'd0, i_q_data.ay} * {32'd0, i_q_data.ay};
                n_p[k].qz = {32'd0, i_q_data.az} * {32'd0, i_q_data.az};
            end
        end else if (k == 1) begin : g_sum
            always_comb begin
                logic signed [19:0] zz;
                n_p[k]    = r_p[k-1];
                n_p[k].v2 = r_p[k-1].qx + r_p[k-1].qy;
                n_p[k].v3 = r_p[k-1].qx + r_p[k-1].qy + r_p[k-1].qz;
                n_p[k].r2 = '0;
                n_p[k].r3 = '0;
                zz = $signed({2'b00, i_clamp, 3'b000});
                // past a right angle start from the sine axis
                if (zz > HALF_PI_Q16) begin
                    n_p[k].cx = '0;
                    n_p[k].cy = GAIN_Q30;
                    n_p[k].cz = zz - HALF_PI_Q16;
                end else begin
                    n_p[k].cx = GAIN_Q30;
                    n_p[k].cy = '0;
                    n_p[k].cz = zz;
                end
            end
        end else if (k < K_VEC) begin : g_sqrt
            localparam int I = k - K_SQRT;
            localparam logic [63:0] B = 64'd1 << (62 - 2 * I);
            always_comb begin
                n_p[k] = r_p[k-1];
                if ({1'b0, r_p[k-1].v2} >= {1'b0, r_p[k-1].r2} + {1'b0, B}) begin
                    n_p[k].v2 = r_p[k-1].v2 - r_p[k-1].r2 - B;
                    n_p[k].r2 = (r_p[k-1].r2 >> 1) + B;
                end else begin
                    n_p[k].r2 = r_p[k-1].r2 >> 1;
                end
                if ({1'b0, r_p[k-1].v3} >= {1'b0, r_p[k-1].r3} + {1'b0, B}) begin
                    n_p[k].v3 = r_p[k-1].v3 - r_p[k-1].r3 - B;
                    n_p[k].r3 = (r_p[k-1].r3 >> 1) + B;
                end else begin
                    n_p[k].r3 = r_p[k-1].r3 >> 1;
                end
                // clamp cordic rides along the root stages
                if (I < CORDIC_N) begin
                    if (r_p[k-1].cz >= 0) begin
                        n_p[k].cx = r_p[k-1].cx - (r_p[k-1].cy >>> I);
                        n_p[k].cy = r_p[k-1].cy + (r_p[k-1].cx >>> I);
                        n_p[k].cz = r_p[k-1].cz - atan_q16(I);
                    end else begin
                        n_p[k].cx = r_p[k-1].cx + (r_p[k-1].cy >>> I);
                        n_p[k].cy = r_p[k-1].cy - (r_p[k-1].cx >>> I);
                        n_p[k].cz = r_p[k-1].cz + atan_q16(I);
                    end
                end
            end
        end else if (k < K_DEC) begin : g_vec
            localparam int I = k - K_VEC;
            always_comb begin
                logic signed [35:0] x, y, rh, zm;
                logic signed [19:0] a;
                n_p[k] = r_p[k-1];
                rh = $signed({4'b0000, r_p[k-1].r2[31:0]});
                zm = $signed({4'b0000, r_p[k-1].iv.az});
                if (I == 0) begin
                    // downward force starts a right angle round
                    x = r_p[k-1].iv.nz ? rh : zm;
                    y = r_p[k-1].iv.nz ? zm : rh;
                    a = r_p[k-1].iv.nz ? HALF_PI_Q16 : 20'sd0;
                end else begin
                    x = r_p[k-1].vx;
                    y = r_p[k-1].vy;
                    a = r_p[k-1].va;
                end
                if (y > 0) begin
                    n_p[k].vx = x + (y >>> I);
                    n_p[k].vy = y - (x >>> I);
                    n_p[k].va = a + atan_q16(I);
                end else begin
                    n_p[k].vx = x - (y >>> I);
                    n_p[k].vy = y + (x >>> I);
                    n_p[k].va = a - atan_q16(I);
                end
            end
        end else if (k == K_DEC) begin : g_dec
            always_comb begin
                logic signed [19:0] r;
                logic [ANG_W-1:0]   t;
                logic [30:0]        si;
                n_p[k] = r_p[k-1];
                r = (r_p[k-1].va + 20'sd4) >>> 3;
                if (r_p[k-1].r2[31:0] == 32'd0) begin
                    t = r_p[k-1].iv.nz ? PI_Q13 : '0;
                end else if (r_p[k-1].va < 0) begin
                    t = '0;
                end else if (r > $signed({5'd0, PI_Q13})) begin
                    t = PI_Q13;
                end else begin
                    t = r[ANG_W-1:0];
                end
                n_p[k].th  = t;
                n_p[k].rej = r_p[k-1].iv.zero || (i_fail_lim >= ENABLE_MIN && t > i_fail_lim);
                n_p[k].clp = (i_clamp >= ENABLE_MIN) && (t > i_clamp);
                si = (r_p[k-1].cy < 0) ? '0 : r_p[k-1].cy[30:0];
                n_p[k].px = {32'd0, si} * {31'd0, r_p[k-1].iv.ax};
                n_p[k].py = {32'd0, si} * {31'd0, r_p[k-1].iv.ay};
            end
        end else if (k == K_NUM) begin : g_num
            always_comb begin
                logic [31:0] rh;
                logic [48:0] d;
                rh = r_p[k-1].r2[31:0];
                n_p[k] = r_p[k-1];
                if (!r_p[k-1].clp) begin
                    d = {17'd0, r_p[k-1].r3[31:0]};
                end else if (rh == 32'd0) begin
                    d = 49'd1;
                end else begin
                    d = {1'b0, rh, 16'd0};
                end
                n_p[k].den = d;
                if (r_p[k-1].clp) begin
                    n_p[k].mx = {2'b00, r_p[k-1].px} + {17'd0, d[48:1]};
                    n_p[k].my = {2'b00, r_p[k-1].py} + {17'd0, d[48:1]};
                end else begin
                    n_p[k].mx = {19'd0, r_p[k-1].iv.ax, 14'd0} + {17'd0, d[48:1]};
                    n_p[k].my = {19'd0, r_p[k-1].iv.ay, 14'd0} + {17'd0, d[48:1]};
                end
                n_p[k].mz  = {19'd0, r_p[k-1].iv.az, 14'd0} + {17'd0, d[48:1]};
                n_p[k].qxq = '0;
                n_p[k].qyq = '0;
                n_p[k].qzq = '0;
            end
        end else begin : g_div
            localparam int BIT = DIV_N - 1 - (k - K_DIV);
            always_comb begin
                logic [64:0] d;
                n_p[k] = r_p[k-1];
                d = {16'd0, r_p[k-1].den} << BIT;
                if (r_p[k-1].mx >= d) begin
                    n_p[k].mx       = r_p[k-1].mx - d;
                    n_p[k].qxq[BIT] = 1'b1;
                end
                if (r_p[k-1].my >= d) begin
                    n_p[k].my       = r_p[k-1].my - d;
                    n_p[k].qyq[BIT] = 1'b1;
                end
                if (r_p[k-1].mz >= d) begin
                    n_p[k].mz       = r_p[k-1].mz - d;
                    n_p[k].qzq[BIT] = 1'b1;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (en) begin
                r_v[k] <= (k == 0) ? i_q_valid : r_v[(k == 0) ? 0 : k - 1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_p[k] <= n_p[k];
            end
        end
    end

    // final signs, clamp outputs and rejection
    always_comb begin
        t_wk                f;
        logic signed [33:0] tz;
        logic [31:0]        sr;
        f  = r_p[NS-1];
        tz = (f.cx + 34'sd32768) >>> 16;
        sr = {1'b0, ((f.cy < 0) ? 31'd0 : f.cy[30:0])} + 32'd32768;
        n_dx = '0;
        n_dy = '0;
        n_dz = '0;
        if (f.rej) begin
            n_dx = '0;
        end else if (f.clp) begin
            if (tz > 34'sd16384) begin
                n_dz = UNIT_Q14;
            end else if (tz < -34'sd16384) begin
                n_dz = -UNIT_Q14;
            end else begin
                n_dz = tz[DIR_W-1:0];
            end
            if (f.r2[31:0] == 32'd0) begin
                n_dx = sr[31:16];
            end else begin
                n_dx = f.iv.nx ? (16'd0 - f.qxq) : f.qxq;
                n_dy = f.iv.ny ? (16'd0 - f.qyq) : f.qyq;
            end
        end else begin
            n_dx = f.iv.nx ? (16'd0 - f.qxq) : f.qxq;
            n_dy = f.iv.ny ? (16'd0 - f.qyq) : f.qyq;
            n_dz = f.iv.nz ? (16'd0 - f.qzq) : f.qzq;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (en) begin
            r_ov <= r_v[NS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_acc <= !r_p[NS-1].rej;
            r_dx  <= n_dx;
            r_dy  <= n_dy;
            r_dz  <= n_dz;
        end
    end

    assign o_m_tvalid = r_ov;
    assign o_m_tuser  = r_acc;
    assign o_m_tdata  = {r_dz, r_dy, r_dx};

endmodule
`default_nettype wire

// ===== rtl/thrust_tilt_limiter_top.sv =====
// top level of the thrust tilt limiter
//
//  channel   dir   handshake                 contents
//  s_axis    in    i_s_tvalid / o_s_tready   force x, y, z (Q16.16)
//  m_axis    out   o_m_tvalid / i_m_tready   accepted flag, unit direction (Q1.14)
//  cfg       in    i_cfg_valid / o_cfg_ready register index, 15-bit angle
//
//  one word per cycle in and out while the output is not stalled; a word
//  taken passes 2 front stages, the queue, 70 back-end stages (among them
//  32 root, 18 tilt cordic and 16 divide steps) and an output register
//  synchronous active-low reset empties the front end, queue and pipeline
//  and clears both angle registers
//  a stalled output freezes the back end; the queue lets the front keep
//  taking words until it fills
`timescale 1ns / 1ps
`default_nettype none
module thrust_tilt_limiter_top
    import ttl_pkg::*;
#(
    parameter int FIFO_DEPTH = 4
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_s_tvalid,
    output logic                      o_s_tready,
    input  wire logic [95:0]          i_s_tdata,   // force_x, force_y, force_z
    output logic                      o_m_tvalid,
    input  wire logic                 i_m_tready,
    output logic                      o_m_tuser,   // accepted
    output logic [47:0]               o_m_tdata,   // dir_x, dir_y, dir_z
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [ANG_W-1:0]     i_cfg_data
);

    logic [ANG_W-1:0] r_fail_lim, r_clamp;
    logic             q_ready, q_push, q_valid, q_pop;
    t_vec             q_in, q_out;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fail_lim <= '0;
            r_clamp    <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_FAIL:  r_fail_lim <= i_cfg_data;
                CFG_CLAMP: r_clamp    <= i_cfg_data;
                default:   r_clamp    <= r_clamp;
            endcase
        end
    end

    ttl_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_q_ready  (q_ready),
        .o_q_push   (q_push),
        .o_q_data   (q_in)
    );

    ttl_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .o_ready (q_ready),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_out)
    );

    ttl_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (q_valid),
        .i_q_data   (q_out),
        .o_q_pop    (q_pop),
        .i_fail_lim (r_fail_lim),
        .i_clamp    (r_clamp),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tuser  (o_m_tuser),
        .o_m_tdata  (o_m_tdata)
    );

endmodule
`default_nettype wire

// ===== rtl/ttl_chk.sv =====
// port checker for the thrust tilt limiter, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
module ttl_chk (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_m_tvalid,
    input wire logic        i_m_tready,
    input wire logic        o_m_tuser,
    input wire logic [47:0] o_m_tdata
);

    // nothing comes out straight after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid after reset");

    // rejected words carry a zero vector
    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tuser) |-> (o_m_tdata == 48'd0))
        else $error("rejected word with non-zero direction");

    // every component stays within a unit
    a_unit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> ($signed(o_m_tdata[15:0]) <= 16'sd16384
                     && $signed(o_m_tdata[15:0]) >= -16'sd16384
                     && $signed(o_m_tdata[31:16]) <= 16'sd16384
                     && $signed(o_m_tdata[31:16]) >= -16'sd16384
                     && $signed(o_m_tdata[47:32]) <= 16'sd16384
                     && $signed(o_m_tdata[47:32]) >= -16'sd16384))
        else $error("direction component out of range");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)
                                         && $stable(o_m_tuser)))
        else $error("stalled word changed");

endmodule

bind thrust_tilt_limiter_top ttl_chk u_ttl_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tuser  (o_m_tuser),
    .o_m_tdata  (o_m_tdata)
);
`default_nettype wire

// ===== tb/sv/thrust_tilt_limiter_checker.sv =====
// channel monitor, direction predictor and comparator for the thrust tilt limiter
`timescale 1ns / 1ps
module thrust_tilt_limiter_checker
    import ttl_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_s_tvalid,
    input  wire logic                 i_s_tready,
    input  wire logic [95:0]          i_s_tdata,
    input  wire logic                 i_m_tvalid,
    input  wire logic                 i_m_tready,
    input  wire logic                 i_m_tuser,
    input  wire logic [47:0]          i_m_tdata,
    input  wire logic                 i_cfg_valid,
    input  wire logic                 i_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [ANG_W-1:0]     i_cfg_data,
    output int                        o_fail_count,
    output int                        o_pending
);

    typedef struct packed {
        logic        accepted;
        logic [15:0] dx;
        logic [15:0] dy;
        logic [15:0] dz;
    } t_dir;

    localparam longint TILT_PI = 25736;
    localparam longint QUARTER_TURN = 102944;
    localparam longint START_GAIN = 652032874;
    localparam int STEPS = 18;
    localparam longint ON_MIN = 9;

    logic [ANG_W-1:0] fail_lim;
    logic [ANG_W-1:0] clamp_lim;
    t_dir dir_q[$];
    int mismatches;

    assign o_fail_count = mismatches;
    assign o_pending = dir_q.size();

    function automatic longint arctan_step(input int i);
        longint tab [0:17] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512, 256,
                               128, 64, 32, 16, 8, 4, 2, 1, 0};
        return tab[i];
    endfunction

    function automatic logic [63:0] int_root(input logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic logic [63:0] round_div(input logic [63:0] n, input logic [63:0] d);
        return (n + d / 2) / d;
    endfunction

    function automatic logic [15:0] signed_pack(input longint v, input logic neg);
        longint s;
        s = neg ? -v : v;
        return s[15:0];
    endfunction

    function automatic longint tilt_angle(input longint rho, input longint az, input logic zneg);
        longint x;
        longint y;
        longint acc;
        longint xn;
        longint yn;
        longint r;
        if (rho == 0) return zneg ? TILT_PI : 0;
        if (!zneg) begin
            x = az; y = rho; acc = 0;
        end else begin
            x = rho; y = az; acc = QUARTER_TURN;
        end
        for (int i = 0; i < STEPS; i++) begin
            if (y > 0) begin
                xn = x + (y >>> i); yn = y - (x >>> i); acc += arctan_step(i);
            end else begin
                xn = x - (y >>> i); yn = y + (x >>> i); acc -= arctan_step(i);
            end
            x = xn; y = yn;
        end
        if (acc < 0) acc = 0;
        r = (acc + 4) >>> 3;
        if (r > TILT_PI) r = TILT_PI;
        return r;
    endfunction

    function automatic t_dir limit_direction(input logic [95:0] w);
        t_dir res;
        logic [63:0] mag [3];
        logic neg [3];
        logic [63:0] m;
        logic [63:0] rho;
        logic [63:0] nrm;
        logic [63:0] dv;
        longint theta;
        longint x;
        longint y;
        longint z;
        longint xn;
        longint yn;
        longint dz;
        res = '0;
        for (int k = 0; k < 3; k++) begin
            neg[k] = w[32*k+31];
            mag[k] = neg[k] ? (64'h1_0000_0000 - {32'd0, w[32*k +: 32]})
                            : {32'd0, w[32*k +: 32]};
        end
        m = mag[0];
        if (mag[1] > m) m = mag[1];
        if (mag[2] > m) m = mag[2];
        if (m == 0) return res;
        while (m < (64'd1 << 30)) begin
            m = m << 1;
            for (int k = 0; k < 3; k++) mag[k] = mag[k] << 1;
        end
        rho = int_root(mag[0] * mag[0] + mag[1] * mag[1]);
        theta = tilt_angle(longint'(rho), longint'(mag[2]), neg[2]);
        if (fail_lim >= ON_MIN && theta > fail_lim) return res;
        res.accepted = 1'b1;
        if (clamp_lim >= ON_MIN && theta > clamp_lim) begin
            // rotate the gain-scaled unit vector round to the clamp angle
            z = longint'(clamp_lim) * 8;
            if (z > QUARTER_TURN) begin
                x = 0; y = START_GAIN; z -= QUARTER_TURN;
            end else begin
                x = START_GAIN; y = 0;
            end
            for (int i = 0; i < STEPS; i++) begin
                if (z >= 0) begin
                    xn = x - (y >>> i); yn = y + (x >>> i); z -= arctan_step(i);
                end else begin
                    xn = x + (y >>> i); yn = y - (x >>> i); z += arctan_step(i);
                end
                x = xn; y = yn;
            end
            if (y < 0) y = 0;
            dz = (x + 32768) >>> 16;
            if (dz > 16384) dz = 16384;
            if (dz < -16384) dz = -16384;
            res.dz = signed_pack(dz, 1'b0);
            if (rho == 0) begin
                res.dx = signed_pack((y + 32768) >>> 16, 1'b0);
            end else begin
                dv = rho << 16;
                res.dx = signed_pack(longint'(round_div(y * mag[0], dv)), neg[0]);
                res.dy = signed_pack(longint'(round_div(y * mag[1], dv)), neg[1]);
            end
        end else begin
            nrm = int_root(mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2]);
            res.dx = signed_pack(longint'(round_div(mag[0] * 16384, nrm)), neg[0]);
            res.dy = signed_pack(longint'(round_div(mag[1] * 16384, nrm)), neg[1]);
            res.dz = signed_pack(longint'(round_div(mag[2] * 16384, nrm)), neg[2]);
        end
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        $display("mismatch %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    initial begin
        mismatches = 0;
    end

    always @(posedge i_clk) begin
        t_dir want;
        if (!i_rst_n) begin
            fail_lim <= '0;
            clamp_lim <= '0;
            dir_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == CFG_FAIL) fail_lim <= i_cfg_data;
                else if (i_cfg_index == CFG_CLAMP) clamp_lim <= i_cfg_data;
            end
            if (i_s_tvalid && i_s_tready) dir_q.push_back(limit_direction(i_s_tdata));
            if (i_m_tvalid && i_m_tready) begin
                if (dir_q.size() == 0) begin
                    report_mismatch("unexpected word", i_m_tdata[15:0], 16'd0);
                end else begin
                    want = dir_q.pop_front();
                    if (i_m_tuser != want.accepted)
                        report_mismatch("accepted", {15'd0, i_m_tuser}, {15'd0, want.accepted});
                    if (i_m_tdata[15:0] != want.dx)
                        report_mismatch("dir_x", i_m_tdata[15:0], want.dx);
                    if (i_m_tdata[31:16] != want.dy)
                        report_mismatch("dir_y", i_m_tdata[31:16], want.dy);
                    if (i_m_tdata[47:32] != want.dz)
                        report_mismatch("dir_z", i_m_tdata[47:32], want.dz);
                end
            end
        end
    end

endmodule

// ===== tb/sv/thrust_tilt_limiter_top_test.sv =====
// stimulus, clock, reset and verdict for the thrust tilt limiter
`timescale 1ns / 1ps
module thrust_tilt_limiter_top_test;
    import ttl_pkg::*;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_s_tvalid;
    logic                 o_s_tready;
    logic [95:0]          i_s_tdata;
    logic                 o_m_tvalid;
    logic                 i_m_tready;
    logic                 o_m_tuser;
    logic [47:0]          o_m_tdata;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [ANG_W-1:0]     i_cfg_data;
    int                   fail_count;
    int                   pending;
    logic                 steady;

    thrust_tilt_limiter_top dut (.*);

    thrust_tilt_limiter_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(i_s_tvalid), .i_s_tready(o_s_tready), .i_s_tdata(i_s_tdata),
        .i_m_tvalid(o_m_tvalid), .i_m_tready(i_m_tready), .i_m_tuser(o_m_tuser),
        .i_m_tdata(o_m_tdata),
        .i_cfg_valid(i_cfg_valid), .i_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        i_m_tready <= steady ? 1'b1 : ($urandom_range(99) >= 36);
    end

    task automatic send_word(input logic [31:0] fx, input logic [31:0] fy, input logic [31:0] fz);
        while (!steady && $urandom_range(99) < 36) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata <= {fz, fy, fx};
        do @(posedge i_clk); while (!o_s_tready);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ANG_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic drain;
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (120) @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_component(input int kind);
        case (kind)
            0:       return $urandom;
            1:       return 32'($signed($urandom_range(64)) - 32);
            2:       return 32'd0;
            3:       return 32'($signed($urandom_range(4000)) - 2000);
            default: return $urandom & 32'h8000_0fff;
        endcase
    endfunction

    task automatic random_words(input int count);
        int shape;
        logic [31:0] zc;
        for (int n = 0; n < count; n++) begin
            shape = $urandom_range(9);
            if (shape < 4) begin
                send_word($urandom, $urandom, $urandom);
            end else if (shape < 7) begin
                // near vertical so tilts spread around the limit values
                zc = $urandom_range(32'h7fff_ffff, 32'h0100_0000);
                if ($urandom_range(1)) zc = -zc;
                send_word(rand_component(3) << $urandom_range(20),
                          rand_component(3) << $urandom_range(20), zc);
            end else begin
                send_word(rand_component($urandom_range(4)), rand_component($urandom_range(4)),
                          rand_component($urandom_range(4)));
            end
        end
    endtask

    initial begin
        logic [ANG_W-1:0] lims [8][2];
        lims = '{'{15'd0, 15'd0}, '{15'd8, 15'd8}, '{15'd9, 15'd9}, '{15'd25736, 15'd25736},
                 '{15'd32767, 15'd32767}, '{15'd12868, 15'd4000}, '{15'd0, 15'd20000},
                 '{15'd3000, 15'd0}};
        steady = 1'b0;
        i_rst_n = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_FAIL;
        i_cfg_data = '0;
        i_m_tready = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // zero vector, extremes and the exact vertical and horizontal cases
        send_word(32'd0, 32'd0, 32'd0);
        send_word(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_word(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
        send_word(32'd0, 32'd0, 32'h0001_0000);
        send_word(32'd0, 32'd0, 32'hffff_0000);
        send_word(32'd0, 32'd0, 32'h8000_0000);
        send_word(32'd1, 32'd0, 32'd0);
        send_word(32'd0, 32'hffff_ffff, 32'd0);
        send_word(32'h8000_0000, 32'd0, 32'd0);
        send_word(32'd1, 32'd1, 32'd1);
        send_word(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
        send_word(32'd3, 32'hfffffffc, 32'h7fff_ffff);
        send_word(32'h0001_0000, 32'd0, 32'hffff_0000);
        drain();
        write_reg(CFG_FAIL, 15'd6434);
        write_reg(CFG_CLAMP, 15'd3217);
        send_word(32'd0, 32'd0, 32'hffff_0000);
        send_word(32'h0001_0000, 32'd0, 32'h0001_0000);
        send_word(32'h0001_0000, 32'h0001_0000, 32'd100);
        send_word(32'd0, 32'd0, 32'h0001_0000);
        send_word(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff);
        drain();

        for (int p = 0; p < 8; p++) begin
            write_reg(CFG_FAIL, lims[p][0]);
            write_reg(CFG_CLAMP, lims[p][1]);
            steady = (p == 3);
            random_words(190);
            drain();
        end
        steady = 1'b0;

        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== thrust_tilt_limiter_top.f =====
rtl/ttl_pkg.sv
rtl/ttl_front.sv
rtl/ttl_fifo.sv
rtl/ttl_back.sv
rtl/thrust_tilt_limiter_top.sv
rtl/ttl_chk.sv
tb/sv/thrust_tilt_limiter_checker.sv
tb/sv/thrust_tilt_limiter_top_test.sv
